// ===== sv/scl_pkg.sv =====
package scl_pkg;

   // character codes the parser looks at
   localparam logic [7:0] CH_NUL   = 8'd0;
   localparam logic [7:0] CH_TAB   = 8'd9;
   localparam logic [7:0] CH_LF    = 8'd10;
   localparam logic [7:0] CH_CR    = 8'd13;
   localparam logic [7:0] CH_SPACE = 8'd32;
   localparam logic [7:0] CH_PLUS  = 8'd43;
   localparam logic [7:0] CH_COMMA = 8'd44;
   localparam logic [7:0] CH_MINUS = 8'd45;
   localparam logic [7:0] CH_ZERO  = 8'd48;
   localparam logic [7:0] CH_NINE  = 8'd57;

   // register indexes
   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_PULSE_MIN     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PULSE_MAX     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ANGLE_LIMIT   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PERIOD        = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHANNEL_LIMIT = 3'd4;
   localparam int CSR_DATA_W = 16;

   // register reset values
   localparam logic [15:0] PULSE_MIN_RESET     = 16'd500;
   localparam logic [15:0] PULSE_MAX_RESET     = 16'd2500;
   localparam logic [7:0]  ANGLE_LIMIT_RESET   = 8'd180;
   localparam logic [15:0] PERIOD_RESET        = 16'd20000;
   localparam logic [6:0]  CHANNEL_LIMIT_RESET = 7'd16;
   localparam logic [6:0]  CHANNEL_MAX         = 7'd64;

   // shared divider: 16-bit quotient; a tick quotient too wide for it is saturated
   localparam int DIV_W     = 16;
   localparam int DIV_NUM_W = 28;
   localparam int DIV_CNT_W = $clog2(DIV_W);
   localparam int PROD_W    = 24;
   localparam int TICK_SHIFT = 12;   // 4096 ticks per period

   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_NO_COMMA    = 3'd1,
      ST_BAD_CHANNEL = 3'd2,
      ST_BAD_ANGLE   = 3'd3,
      ST_OVERFLOW    = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      PH_BLANK  = 3'b001,
      PH_DIGITS = 3'b010,
      PH_STOP   = 3'b100
   } num_phase_type;

   typedef struct packed {
      num_phase_type phase;
      logic          negative;
      logic [15:0]   value;
   } num_type;

   localparam num_type NUM_CLEAR = '{phase: PH_BLANK, negative: 1'b0, value: 16'd0};

   // controller to datapath
   typedef struct packed {
      logic accept;     // input word taken this cycle
      logic mul;        // angle times pulse span
      logic div_start;  // load divider
      logic div_tick;   // divider operands: 0 interpolation, 1 tick conversion
      logic add;        // pulse width from quotient
      logic out_load;   // load ok result into output register
   } scl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic imm_result;  // accepted word gives an error or overflow result now
      logic need_calc;   // accepted word ends a good line
      logic div_done;    // divider finishes at this edge
   } scl_stat_type;

   function automatic logic is_blank(logic [7:0] c);
      return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
   endfunction

   function automatic num_type num_feed(num_type n, logic [7:0] c);
      num_type     r;
      logic        digit;
      logic [19:0] v;
      r     = n;
      digit = (c >= CH_ZERO) && (c <= CH_NINE);
      v     = 20'(n.value) * 20'd10 + {16'd0, c[3:0]};
      unique case (n.phase)
         PH_BLANK: begin
            if (is_blank(c)) begin
               r = n;
            end else if (c == CH_PLUS || c == CH_MINUS) begin
               r.negative = (c == CH_MINUS);
               r.phase    = PH_DIGITS;
            end else if (digit) begin
               r.phase = PH_DIGITS;
               r.value = (v > 20'd65535) ? 16'hFFFF : v[15:0];
            end else begin
               r.phase = PH_STOP;
            end
         end
         PH_DIGITS: begin
            if (digit) begin
               r.value = (v > 20'd65535) ? 16'hFFFF : v[15:0];
            end else begin
               r.phase = PH_STOP;
            end
         end
         PH_STOP: begin
            r = n;
         end
         default: begin
            r = n;
         end
      endcase
      return r;
   endfunction

endpackage

// ===== sv/scl_div.sv =====
module scl_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [scl_pkg::DIV_NUM_W-1:0]  dividend,
   input  logic [scl_pkg::DIV_W-1:0]      divisor,
   output logic                           done,
   output logic [scl_pkg::DIV_W-1:0]      quotient
);
   import scl_pkg::*;

   // restoring divider, one quotient bit per cycle; the caller must keep
   // the quotient within DIV_W bits, which the divider does not enforce
   logic                 busy_ff, busy_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0]     rem_ff, rem_in;
   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [DIV_W:0]       rem_sh;
   logic                 fits;

   assign rem_sh = {rem_ff, quo_ff[DIV_W-1]};
   assign fits   = rem_sh >= {1'b0, divisor};
   assign done   = busy_ff && (cnt_ff == DIV_CNT_W'(DIV_W - 1));
   assign quotient = quo_ff;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = DIV_W'(dividend[DIV_NUM_W-1:DIV_W]);
         quo_in  = dividend[DIV_W-1:0];
      end else if (busy_ff) begin
         rem_in = fits ? DIV_W'(rem_sh - {1'b0, divisor}) : rem_sh[DIV_W-1:0];
         quo_in = {quo_ff[DIV_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (done) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

endmodule

// ===== sv/scl_dp.sv =====
module scl_dp #(
   parameter int LINE_BUF_SIZE = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  scl_pkg::scl_cmd_type              cmd,
   output scl_pkg::scl_stat_type             stat,
   input  logic [7:0]                        req_rx_byte,
   output logic [2:0]                        rsp_status,
   output logic [5:0]                        rsp_channel,
   output logic [15:0]                       rsp_tick,
   input  logic                              csr_write,
   input  logic [scl_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [scl_pkg::CSR_DATA_W-1:0]    csr_data
);
   import scl_pkg::*;

   localparam int LEN_W = $clog2(LINE_BUF_SIZE);

   // configuration
   logic [15:0] pulse_min_ff, pulse_max_ff, period_ff;
   logic [7:0]  angle_limit_ff;
   logic [6:0]  channel_limit_ff;

   // line state
   logic [LEN_W-1:0] len_ff, len_in;
   logic             comma_ff, comma_in;
   logic             zero_ff, zero_in;
   num_type          chan_ff, chan_in;
   num_type          ang_ff, ang_in;

   // calculation registers
   logic [5:0]        pend_chan_ff;
   logic [7:0]        angle_ff;
   logic [15:0]       span_ff;
   logic              span_neg_ff;
   logic [PROD_W-1:0] prod_ff;
   logic [15:0]       pulse_ff;

   // output payload
   status_type  out_status_ff;
   logic [5:0]  out_chan_ff;
   logic [15:0] out_tick_ff;

   logic [7:0]           c;
   logic                 eol;
   logic [6:0]           climit;
   logic                 bad_chan, bad_ang;
   status_type           line_status;
   logic [DIV_NUM_W-1:0] div_num;
   logic [DIV_W-1:0]     div_den;
   logic                 div_done;
   logic [DIV_W-1:0]     div_quo;
   logic [15:0]          interp;
   logic                 tick_sat;

   assign c        = req_rx_byte;
   assign eol      = (c == CH_LF) || (c == CH_CR);
   assign climit   = (channel_limit_ff > CHANNEL_MAX) ? CHANNEL_MAX : channel_limit_ff;
   assign bad_chan = (chan_ff.negative && chan_ff.value != 16'd0) ||
                     (chan_ff.value >= {9'd0, climit});
   assign bad_ang  = (ang_ff.negative && ang_ff.value != 16'd0) ||
                     (ang_ff.value > {8'd0, angle_limit_ff});

   always_comb begin
      priority if (!comma_ff) begin
         line_status = ST_NO_COMMA;
      end else if (bad_chan) begin
         line_status = ST_BAD_CHANNEL;
      end else if (bad_ang) begin
         line_status = ST_BAD_ANGLE;
      end else begin
         line_status = ST_OK;
      end
   end

   always_comb begin
      len_in          = len_ff;
      comma_in        = comma_ff;
      zero_in         = zero_ff;
      chan_in         = chan_ff;
      ang_in          = ang_ff;
      stat.imm_result = 1'b0;
      stat.need_calc  = 1'b0;
      stat.div_done   = div_done;
      if (cmd.accept) begin
         if (eol) begin
            if (len_ff != '0) begin
               len_in          = '0;
               comma_in        = 1'b0;
               zero_in         = 1'b0;
               chan_in         = NUM_CLEAR;
               ang_in          = NUM_CLEAR;
               stat.need_calc  = (line_status == ST_OK);
               stat.imm_result = (line_status != ST_OK);
            end
         end else if (len_ff >= LEN_W'(LINE_BUF_SIZE - 1)) begin
            len_in          = '0;
            comma_in        = 1'b0;
            zero_in         = 1'b0;
            chan_in         = NUM_CLEAR;
            ang_in          = NUM_CLEAR;
            stat.imm_result = 1'b1;
         end else begin
            len_in  = len_ff + 1'b1;
            zero_in = zero_ff || (c == CH_NUL);
            if (!zero_in) begin
               if (comma_ff) begin
                  ang_in = num_feed(ang_ff, c);
               end else begin
                  chan_in = num_feed(chan_ff, c);
                  if (c == CH_COMMA) begin
                     comma_in = 1'b1;
                  end
               end
            end
         end
      end
   end

   // shared divider: angle span interpolation, then tick conversion
   assign div_num = cmd.div_tick ? {pulse_ff, TICK_SHIFT'(0)} :
                                   DIV_NUM_W'(prod_ff);
   assign div_den = cmd.div_tick ? period_ff : DIV_W'(angle_limit_ff);

   scl_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign interp   = (angle_limit_ff == 8'd0) ? 16'd0 : div_quo;
   // quotient above 16 bits exactly when pulse >= 16 * period
   assign tick_sat = {4'd0, pulse_ff} >= {period_ff, 4'd0};

   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_min_ff     <= PULSE_MIN_RESET;
         pulse_max_ff     <= PULSE_MAX_RESET;
         angle_limit_ff   <= ANGLE_LIMIT_RESET;
         period_ff        <= PERIOD_RESET;
         channel_limit_ff <= CHANNEL_LIMIT_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_PULSE_MIN:     pulse_min_ff     <= csr_data[15:0];
            CSR_PULSE_MAX:     pulse_max_ff     <= csr_data[15:0];
            CSR_ANGLE_LIMIT:   angle_limit_ff   <= csr_data[7:0];
            CSR_PERIOD:        period_ff        <= csr_data[15:0];
            CSR_CHANNEL_LIMIT: channel_limit_ff <= csr_data[6:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff   <= '0;
         comma_ff <= 1'b0;
         zero_ff  <= 1'b0;
         chan_ff  <= NUM_CLEAR;
         ang_ff   <= NUM_CLEAR;
      end else begin
         len_ff   <= len_in;
         comma_ff <= comma_in;
         zero_ff  <= zero_in;
         chan_ff  <= chan_in;
         ang_ff   <= ang_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stat.need_calc) begin
         pend_chan_ff <= chan_ff.value[5:0];
         angle_ff     <= ang_ff.value[7:0];
         span_neg_ff  <= pulse_max_ff < pulse_min_ff;
         span_ff      <= (pulse_max_ff < pulse_min_ff) ? pulse_min_ff - pulse_max_ff :
                                                         pulse_max_ff - pulse_min_ff;
      end
      if (cmd.mul) begin
         prod_ff <= PROD_W'(angle_ff) * PROD_W'(span_ff);
      end
      if (cmd.add) begin
         pulse_ff <= span_neg_ff ? pulse_min_ff - interp : pulse_min_ff + interp;
      end
      if (stat.imm_result) begin
         out_status_ff <= (eol) ? line_status : ST_OVERFLOW;
         out_chan_ff   <= 6'd0;
         out_tick_ff   <= 16'd0;
      end else if (cmd.out_load) begin
         out_status_ff <= ST_OK;
         out_chan_ff   <= pend_chan_ff;
         out_tick_ff   <= tick_sat ? 16'hFFFF : div_quo;
      end
   end

   assign rsp_status  = out_status_ff;
   assign rsp_channel = out_chan_ff;
   assign rsp_tick    = out_tick_ff;

endmodule

// ===== sv/scl_ctrl.sv =====
module scl_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output scl_pkg::scl_cmd_type   cmd,
   input  scl_pkg::scl_stat_type  stat
);
   import scl_pkg::*;

   typedef enum logic [7:0] {
      S_IDLE   = 8'b0000_0001,
      S_MUL    = 8'b0000_0010,
      S_START1 = 8'b0000_0100,
      S_WAIT1  = 8'b0000_1000,
      S_ADD    = 8'b0001_0000,
      S_START2 = 8'b0010_0000,
      S_WAIT2  = 8'b0100_0000,
      S_DONE   = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE) || !out_free;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      cmd.accept    = req_valid && !req_stall;
      unique case (state_ff)
         S_IDLE: begin
            if (cmd.accept && stat.need_calc) begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_START1;
         end
         S_START1: begin
            cmd.div_start = 1'b1;
            state_in      = S_WAIT1;
         end
         S_WAIT1: begin
            if (stat.div_done) begin
               state_in = S_ADD;
            end
         end
         S_ADD: begin
            cmd.add  = 1'b1;
            state_in = S_START2;
         end
         S_START2: begin
            cmd.div_start = 1'b1;
            cmd.div_tick  = 1'b1;
            state_in      = S_WAIT2;
         end
         S_WAIT2: begin
            cmd.div_tick = 1'b1;
            if (stat.div_done) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            cmd.div_tick = 1'b1;
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if ((cmd.accept && stat.imm_result) || cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // a new result never lands on a word still waiting at the output
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      ((cmd.accept && stat.imm_result) || cmd.out_load) |-> out_free)
      else $error("result loaded over pending output word");

   // divider only finishes while the controller waits on it
   a_div_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      stat.div_done |-> (state_ff == S_WAIT1 || state_ff == S_WAIT2))
      else $error("divider finished outside a wait state");

   // a good line end starts the calculation
   a_calc_starts: assert property (@(posedge clock) disable iff (reset)
      (cmd.accept && stat.need_calc) |=> (state_ff == S_MUL))
      else $error("good line end did not start calculation");

   // one line end never yields both an immediate and a calculated result
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      !(stat.imm_result && stat.need_calc))
      else $error("line end flagged for two results");

endmodule

// ===== sv/servo_command_line_parser.sv =====
// servo command line parser
// req channel: one received byte per word (req_rx_byte), valid/stall handshake.
// lines read "channel,angle" and end on CR or LF; empty lines give nothing.
// rsp channel: one word per non-empty line end or per overflow, carrying
// rsp_status, rsp_channel and rsp_tick (channel and tick are zero on error).
// csr channel: valid/ready write of register csr_index with csr_data; ready
// is always high; registers are pulse min, pulse max, angle limit,
// pwm period and channel limit in that index order.
// timing: a data byte is taken while idle with the output free; an error or
// overflow result is in the output register in the cycle after its byte; an
// ok result holds off input until loaded, set by two passes of the shared
// restoring divider (angle interpolation, then tick conversion).
// the output register holds one result word; while that word waits under a
// stalled receiver every further input word is held off until it is taken.
// reset (synchronous) restores register defaults and clears the line state.
module servo_command_line_parser #(
   parameter int LINE_BUF_SIZE = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   // byte input
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [7:0]                        req_rx_byte,
   // result output
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [2:0]                        rsp_status,
   output logic [5:0]                        rsp_channel,
   output logic [15:0]                       rsp_tick,
   // register writes
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [scl_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [scl_pkg::CSR_DATA_W-1:0]    csr_data
);
   import scl_pkg::*;

   scl_cmd_type  cmd;
   scl_stat_type stat;

   // writes go straight into the registers, so the port never pushes back
   assign csr_ready = 1'b1;

   // sequencer: byte accept, multiply, two divider passes, result load
   scl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .stat      (stat)
   );

   // line parser, configuration registers, arithmetic and output payload
   scl_dp #(
      .LINE_BUF_SIZE (LINE_BUF_SIZE)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .req_rx_byte (req_rx_byte),
      .rsp_status  (rsp_status),
      .rsp_channel (rsp_channel),
      .rsp_tick    (rsp_tick),
      .csr_write   (csr_valid && csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

endmodule
